// File: design/ilff_pkg.sv
// Package for the implicit-list first-fit heap allocator.
// Holds payload types, status codes, controller states and datapath commands.
// No dependencies; every other design file but ilff_stream_if imports it.
package ilff_pkg;

  // Default heap size in 8-byte words.
  localparam int unsigned HEAP_WORDS_DEF = 65536;

  // Field widths fixed by the interface.
  localparam int unsigned TAG_W  = 20;
  localparam int unsigned REQ_W  = 20;
  localparam int unsigned ADDR_W = 19;
  localparam int unsigned STAT_W = 2;

  // Growth used by the init sequence and the reset value of the chunk register.
  localparam logic [TAG_W-1:0] CHUNK_RESET = 20'd16384;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_LIMIT = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
  } ilff_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [STAT_W-1:0] status;
  } ilff_rsp_t;

  // What the controller does once a merge has finished.
  typedef enum logic [1:0] {
    MODE_INIT,
    MODE_ALLOC,
    MODE_FREE
  } ilff_mode_e;

  typedef enum logic [5:0] {
    ST_INIT0, ST_INIT1, ST_INIT2,
    ST_IDLE, ST_DISPATCH, ST_ZERO,
    ST_WALK_RD, ST_WALK_CHK,
    ST_GROW_EXT, ST_GROW_CALC, ST_GROW_W1, ST_GROW_W2, ST_GROW_W3,
    ST_M_RD1, ST_M_RD2, ST_M_RD3, ST_M_DEC,
    ST_MP_W, ST_MP_R, ST_MP_W2,
    ST_MQ_ADD, ST_MN_W1, ST_MN_W2,
    ST_MB_ADD2, ST_MB_W1, ST_MB_R, ST_MB_W2,
    ST_F_RD, ST_F_CHK, ST_F_W1, ST_F_W2,
    ST_P_RD, ST_P_CHK, ST_P_S1, ST_P_S2, ST_P_S3, ST_P_S4, ST_P_N1, ST_P_N2,
    ST_FAIL, ST_DONE
  } ilff_state_e;

  typedef enum logic [5:0] {
    CMD_NOP, CMD_ACCEPT,
    CMD_INIT_W8, CMD_INIT_W16, CMD_INIT_W24,
    CMD_ZERO,
    CMD_WALK_RD, CMD_WALK_STEP,
    CMD_GROW_EXT, CMD_GROW_CALC, CMD_GROW_W1, CMD_GROW_W2, CMD_GROW_W3,
    CMD_M_RD1, CMD_M_RD2, CMD_M_RD3, CMD_M_DEC,
    CMD_MP_W, CMD_MP_R, CMD_MP_W2,
    CMD_MQ_ADD, CMD_MN_W1, CMD_MN_W2,
    CMD_MB_ADD2, CMD_MB_W1, CMD_MB_R, CMD_MB_W2,
    CMD_F_RD, CMD_F_CHK, CMD_F_W1, CMD_F_W2,
    CMD_P_RD, CMD_P_CHK, CMD_P_S1, CMD_P_S2, CMD_P_S3, CMD_P_S4,
    CMD_P_N1, CMD_P_N2,
    CMD_FAIL, CMD_PUBLISH
  } ilff_cmd_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic free_pre_ok;
    logic walk_end;
    logic tag_zero;
    logic tag_fit;
    logic tag_alloc;
    logic grow_ok;
    logic prev_alloc;
    logic next_alloc;
    logic free_ok;
    logic split;
    logic out_free;
  } ilff_flags_t;

endpackage

// File: design/ilff_stream_if.sv
// Valid/ready channel that carries one word of a given payload type.
// Standalone; the payload type comes from ilff_pkg at the instance.
interface ilff_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/implicit_list_first_fit_allocator.sv
// Implicit-list first-fit heap allocator with boundary tags.
// An allocate walks the block headers and adds placement, growth and merge.
// One word at a time; the walk is bound by the single tag memory read port.
// Reset runs an init sequence that writes the prologue, the epilogue and the
// first chunk; the tag memory itself is not cleared.
module implicit_list_first_fit_allocator #(
  parameter int unsigned HEAP_WORDS = ilff_pkg::HEAP_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ilff_stream_if.sink                req_i,
  ilff_stream_if.source              rsp_o,
  input  logic                       cfg_we_i,
  input  logic [ilff_pkg::TAG_W-1:0] cfg_wdata_i
);
  import ilff_pkg::*;

  ilff_cmd_e   cmd;
  ilff_flags_t flags;

  // Sequencer.
  ilff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // Tag memory, heap registers and result register.
  ilff_datapath #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .req_payload_i (req_i.payload),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_payload_o (rsp_o.payload)
  );

endmodule

// File: design/ilff_datapath.sv
// Datapath of the allocator: tag memory, heap registers and result register.
// Executes one command from ilff_ctrl per cycle; uses ilff_pkg.
module ilff_datapath #(
  parameter int unsigned HEAP_WORDS = ilff_pkg::HEAP_WORDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ilff_pkg::ilff_cmd_e                cmd_i,
  output ilff_pkg::ilff_flags_t              flags_o,
  input  ilff_pkg::ilff_req_t                req_payload_i,
  input  logic                               cfg_we_i,
  input  logic [ilff_pkg::TAG_W-1:0]         cfg_wdata_i,
  input  logic                               rsp_ready_i,
  output logic                               rsp_valid_o,
  output ilff_pkg::ilff_rsp_t                rsp_payload_o
);
  import ilff_pkg::*;

  localparam int unsigned IW = $clog2(HEAP_WORDS);
  localparam int unsigned BW = IW + 4;
  localparam int unsigned OW = ((BW > 21) ? BW : 21) + 2;
  localparam logic [OW-1:0] HEAP_BYTES = OW'(HEAP_WORDS) << 3;

  // Tag memory and its registered read port.
  logic [TAG_W-1:0] mem [HEAP_WORDS];
  logic [TAG_W-1:0] rdata_q;
  logic             rin_q;

  logic             rd_en, wr_en, rd_in;
  logic [OW-1:0]    rd_off, wr_off, wr_val;

  logic [OW-1:0]    bp_q, bp_d, hb_q, hb_d, sz_q, sz_d, nbp_q, nbp_d, pbp_q, pbp_d;
  logic [OW-1:0]    asize_q, asize_d, ext_q, ext_d;
  logic [TAG_W-1:0] r1_q, r1_d, r3_q, r3_d, csize_q, csize_d, chunk_q;
  logic             pa_q, pa_d, na_q, na_d, op_q, op_d, zero_q, zero_d;
  logic             pre_ok_q, pre_ok_d;
  logic [ADDR_W-1:0] res_q, res_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  ilff_rsp_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [TAG_W-1:0] tag, tsize;
  logic             talloc;
  logic [OW-1:0]    tsz_w, gsz, csz_w, rem_w, acc_asize;
  logic [REQ_W:0]   req_sum;

  // Tag read data; an out-of-range read returns zero.
  assign tag    = rin_q ? rdata_q : '0;
  assign tsize  = {tag[TAG_W-1:1], 1'b0};
  assign talloc = tag[0];
  assign tsz_w  = OW'(tsize);
  assign csz_w  = OW'(csize_q);
  assign rem_w  = csz_w - asize_q;
  assign rd_in  = rd_off < HEAP_BYTES;

  // Growth rounds down to whole words and then up to an even word count.
  assign gsz = {ext_q[OW-1:4], 4'b0} + (ext_q[3] ? OW'(16) : OW'(0));

  // Request rounded to a 16-byte multiple with overhead, minimum 32 bytes.
  assign req_sum   = {1'b0, req_payload_i.request_size} + (REQ_W+1)'(31);
  assign acc_asize = (req_payload_i.request_size <= REQ_W'(16)) ? OW'(32)
                   : OW'({req_sum[REQ_W:4], 4'b0});

  // Flags for the controller.
  always_comb begin
    flags_o.is_free     = op_q;
    flags_o.req_zero    = zero_q;
    flags_o.free_pre_ok = pre_ok_q;
    flags_o.walk_end    = bp_q >= HEAP_BYTES;
    flags_o.tag_zero    = tsize == '0;
    flags_o.tag_fit     = !talloc && (asize_q <= tsz_w);
    flags_o.tag_alloc   = talloc;
    flags_o.grow_ok     = (hb_q + gsz) <= HEAP_BYTES;
    flags_o.prev_alloc  = pa_q;
    flags_o.next_alloc  = na_q;
    flags_o.free_ok     = talloc && (tsize >= TAG_W'(16)) && ((bp_q + tsz_w) <= hb_q);
    flags_o.split       = (tsz_w < asize_q) || ((tsz_w - asize_q) >= OW'(32));
    flags_o.out_free    = !out_valid_q || rsp_ready_i;
  end

  // Command decode.
  always_comb begin
    bp_d = bp_q; hb_d = hb_q; sz_d = sz_q; nbp_d = nbp_q; pbp_d = pbp_q;
    asize_d = asize_q; ext_d = ext_q; r1_d = r1_q; r3_d = r3_q; csize_d = csize_q;
    pa_d = pa_q; na_d = na_q; op_d = op_q; zero_d = zero_q; pre_ok_d = pre_ok_q;
    res_d = res_q; stat_d = stat_q; out_d = out_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    rd_en = 1'b0; rd_off = '0; wr_en = 1'b0; wr_off = '0; wr_val = '0;
    unique case (cmd_i)
      CMD_ACCEPT: begin
        op_d     = req_payload_i.operation;
        zero_d   = req_payload_i.request_size == '0;
        pre_ok_d = (req_payload_i.block_address[3:0] == 4'd0)
                && (req_payload_i.block_address >= ADDR_W'(32))
                && (OW'(req_payload_i.block_address) < hb_q);
        asize_d  = acc_asize;
        bp_d     = (req_payload_i.operation == OP_FREE)
                 ? OW'(req_payload_i.block_address) : OW'(16);
        res_d    = '0;
        stat_d   = STATUS_DONE;
      end
      CMD_INIT_W8:  begin wr_en = 1'b1; wr_off = OW'(8);  wr_val = OW'(17); end
      CMD_INIT_W16: begin wr_en = 1'b1; wr_off = OW'(16); wr_val = OW'(17); end
      CMD_INIT_W24: begin
        wr_en = 1'b1; wr_off = OW'(24); wr_val = OW'(1);
        hb_d  = OW'(32);
        ext_d = OW'(CHUNK_RESET);
      end
      CMD_ZERO: stat_d = STATUS_ZERO;
      CMD_WALK_RD: begin rd_en = 1'b1; rd_off = bp_q - OW'(8); end
      CMD_WALK_STEP: begin
        if (tsize != '0 && !(!talloc && (asize_q <= tsz_w))) begin
          bp_d = bp_q + tsz_w;
        end
      end
      CMD_GROW_EXT: ext_d = (asize_q > OW'(chunk_q)) ? asize_q : OW'(chunk_q);
      CMD_GROW_CALC: begin
        if ((hb_q + gsz) <= HEAP_BYTES) begin
          bp_d = hb_q;
          hb_d = hb_q + gsz;
          sz_d = gsz;
        end
      end
      CMD_GROW_W1: begin wr_en = 1'b1; wr_off = bp_q - OW'(8); wr_val = sz_q; end
      CMD_GROW_W2: begin wr_en = 1'b1; wr_off = bp_q + sz_q - OW'(16); wr_val = sz_q; end
      CMD_GROW_W3: begin wr_en = 1'b1; wr_off = bp_q + sz_q - OW'(8); wr_val = OW'(1); end
      // Merge: read own header, previous footer and next header.
      CMD_M_RD1: begin rd_en = 1'b1; rd_off = bp_q - OW'(8); end
      CMD_M_RD2: begin
        r1_d  = tsize;
        sz_d  = tsz_w;
        nbp_d = bp_q + tsz_w;
        rd_en = 1'b1; rd_off = bp_q - OW'(16);
      end
      CMD_M_RD3: begin
        pbp_d = bp_q - tsz_w;
        pa_d  = talloc;
        rd_en = 1'b1; rd_off = nbp_q - OW'(8);
      end
      CMD_M_DEC: begin
        na_d  = talloc;
        r3_d  = tsize;
        if (pa_q) begin
          sz_d = sz_q + tsz_w;
        end
        rd_en = 1'b1; rd_off = pbp_q - OW'(8);
      end
      CMD_MP_W:  begin wr_en = 1'b1; wr_off = bp_q - OW'(8); wr_val = sz_q; end
      CMD_MP_R:  begin rd_en = 1'b1; rd_off = bp_q - OW'(8); end
      CMD_MP_W2: begin wr_en = 1'b1; wr_off = bp_q + tsz_w - OW'(16); wr_val = sz_q; end
      CMD_MQ_ADD: begin
        sz_d  = sz_q + tsz_w;
        rd_en = 1'b1; rd_off = nbp_q + OW'(r3_q) - OW'(16);
      end
      CMD_MN_W1: begin wr_en = 1'b1; wr_off = bp_q + OW'(r1_q) - OW'(16); wr_val = sz_q; end
      CMD_MN_W2: begin
        wr_en = 1'b1; wr_off = pbp_q - OW'(8); wr_val = sz_q;
        bp_d  = pbp_q;
      end
      CMD_MB_ADD2: sz_d = sz_q + tsz_w;
      CMD_MB_W1: begin wr_en = 1'b1; wr_off = pbp_q - OW'(8); wr_val = sz_q; end
      CMD_MB_R:  begin rd_en = 1'b1; rd_off = nbp_q - OW'(8); end
      CMD_MB_W2: begin
        wr_en = 1'b1; wr_off = nbp_q + tsz_w - OW'(16); wr_val = sz_q;
        bp_d  = pbp_q;
      end
      // Free: check the header, then clear the allocated bit in both tags.
      CMD_F_RD:  begin rd_en = 1'b1; rd_off = bp_q - OW'(8); end
      CMD_F_CHK: r1_d = tsize;
      CMD_F_W1:  begin wr_en = 1'b1; wr_off = bp_q - OW'(8); wr_val = OW'(r1_q); end
      CMD_F_W2:  begin
        wr_en = 1'b1; wr_off = bp_q + OW'(r1_q) - OW'(16); wr_val = OW'(r1_q);
      end
      // Placement, with or without a split.
      CMD_P_RD:  begin rd_en = 1'b1; rd_off = bp_q - OW'(8); end
      CMD_P_CHK: begin
        csize_d = tsize;
        res_d   = bp_q[ADDR_W-1:0];
      end
      CMD_P_S1: begin wr_en = 1'b1; wr_off = bp_q - OW'(8); wr_val = asize_q | OW'(1); end
      CMD_P_S2: begin
        wr_en = 1'b1; wr_off = bp_q + asize_q - OW'(16); wr_val = asize_q | OW'(1);
      end
      CMD_P_S3: begin wr_en = 1'b1; wr_off = bp_q + asize_q - OW'(8); wr_val = rem_w; end
      CMD_P_S4: begin wr_en = 1'b1; wr_off = bp_q + csz_w - OW'(16); wr_val = rem_w; end
      CMD_P_N1: begin wr_en = 1'b1; wr_off = bp_q - OW'(8); wr_val = csz_w | OW'(1); end
      CMD_P_N2: begin
        wr_en = 1'b1; wr_off = bp_q + csz_w - OW'(16); wr_val = csz_w | OW'(1);
      end
      CMD_FAIL: stat_d = STATUS_LIMIT;
      CMD_PUBLISH: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_d.result_address = res_q;
          out_d.status         = stat_q;
          out_valid_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Tag memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_off < HEAP_BYTES)) begin
      mem[wr_off[IW+2:3]] <= wr_val[TAG_W-1:0];
    end
    if (rd_en) begin
      rin_q <= rd_in;
      if (rd_in) begin
        rdata_q <= mem[rd_off[IW+2:3]];
      end
    end
  end

  // Control registers: heap break, chunk size and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q        <= OW'(32);
      chunk_q     <= CHUNK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      hb_q        <= hb_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        chunk_q <= cfg_wdata_i;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    bp_q <= bp_d; sz_q <= sz_d; nbp_q <= nbp_d; pbp_q <= pbp_d;
    asize_q <= asize_d; ext_q <= ext_d; r1_q <= r1_d; r3_q <= r3_d;
    csize_q <= csize_d; pa_q <= pa_d; na_q <= na_d; op_q <= op_d;
    zero_q <= zero_d; pre_ok_q <= pre_ok_d; res_q <= res_d; stat_q <= stat_d;
    out_q <= out_d;
  end

  assign rsp_valid_o   = out_valid_q;
  assign rsp_payload_o = out_q;

endmodule

// File: design/ilff_ctrl.sv
// Controller of the allocator: sequences init, walk, grow, merge, free and placement.
// Drives ilff_datapath with commands; uses ilff_pkg.
module ilff_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ilff_pkg::ilff_flags_t flags_i,
  output ilff_pkg::ilff_cmd_e   cmd_o
);
  import ilff_pkg::*;

  ilff_state_e state_q, state_d;
  ilff_mode_e  mode_q, mode_d;
  ilff_state_e after_merge;

  // Where a finished merge continues.
  always_comb begin
    unique case (mode_q)
      MODE_ALLOC: after_merge = ST_P_RD;
      MODE_FREE:  after_merge = ST_DONE;
      default:    after_merge = ST_IDLE;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    unique case (state_q)
      ST_INIT0: state_d = ST_INIT1;
      ST_INIT1: state_d = ST_INIT2;
      ST_INIT2: state_d = ST_GROW_CALC;
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (flags_i.is_free) begin
          mode_d  = MODE_FREE;
          state_d = flags_i.free_pre_ok ? ST_F_RD : ST_DONE;
        end else begin
          mode_d  = MODE_ALLOC;
          state_d = flags_i.req_zero ? ST_ZERO : ST_WALK_RD;
        end
      end
      ST_ZERO: state_d = ST_DONE;
      ST_WALK_RD: state_d = flags_i.walk_end ? ST_GROW_EXT : ST_WALK_CHK;
      ST_WALK_CHK: begin
        priority if (flags_i.tag_zero) begin
          state_d = ST_GROW_EXT;
        end else if (flags_i.tag_fit) begin
          state_d = ST_P_RD;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_GROW_EXT: state_d = ST_GROW_CALC;
      ST_GROW_CALC: begin
        priority if (flags_i.grow_ok) begin
          state_d = ST_GROW_W1;
        end else if (mode_q == MODE_INIT) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FAIL;
        end
      end
      ST_GROW_W1: state_d = ST_GROW_W2;
      ST_GROW_W2: state_d = ST_GROW_W3;
      ST_GROW_W3: state_d = ST_M_RD1;
      ST_M_RD1:   state_d = ST_M_RD2;
      ST_M_RD2:   state_d = ST_M_RD3;
      ST_M_RD3:   state_d = ST_M_DEC;
      ST_M_DEC: begin
        priority if (flags_i.prev_alloc && flags_i.tag_alloc) begin
          state_d = after_merge;
        end else if (flags_i.prev_alloc) begin
          state_d = ST_MP_W;
        end else begin
          state_d = ST_MQ_ADD;
        end
      end
      ST_MP_W:    state_d = ST_MP_R;
      ST_MP_R:    state_d = ST_MP_W2;
      ST_MP_W2:   state_d = after_merge;
      ST_MQ_ADD:  state_d = flags_i.next_alloc ? ST_MN_W1 : ST_MB_ADD2;
      ST_MN_W1:   state_d = ST_MN_W2;
      ST_MN_W2:   state_d = after_merge;
      ST_MB_ADD2: state_d = ST_MB_W1;
      ST_MB_W1:   state_d = ST_MB_R;
      ST_MB_R:    state_d = ST_MB_W2;
      ST_MB_W2:   state_d = after_merge;
      ST_F_RD:    state_d = ST_F_CHK;
      ST_F_CHK:   state_d = flags_i.free_ok ? ST_F_W1 : ST_DONE;
      ST_F_W1:    state_d = ST_F_W2;
      ST_F_W2:    state_d = ST_M_RD1;
      ST_P_RD:    state_d = ST_P_CHK;
      ST_P_CHK:   state_d = flags_i.split ? ST_P_S1 : ST_P_N1;
      ST_P_S1:    state_d = ST_P_S2;
      ST_P_S2:    state_d = ST_P_S3;
      ST_P_S3:    state_d = ST_P_S4;
      ST_P_S4:    state_d = ST_DONE;
      ST_P_N1:    state_d = ST_P_N2;
      ST_P_N2:    state_d = ST_DONE;
      ST_FAIL:    state_d = ST_DONE;
      ST_DONE: begin
        if (flags_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command for the datapath in each state.
  always_comb begin
    req_ready_o = state_q == ST_IDLE;
    unique case (state_q)
      ST_INIT0:     cmd_o = CMD_INIT_W8;
      ST_INIT1:     cmd_o = CMD_INIT_W16;
      ST_INIT2:     cmd_o = CMD_INIT_W24;
      ST_IDLE:      cmd_o = req_valid_i ? CMD_ACCEPT : CMD_NOP;
      ST_ZERO:      cmd_o = CMD_ZERO;
      ST_WALK_RD:   cmd_o = CMD_WALK_RD;
      ST_WALK_CHK:  cmd_o = CMD_WALK_STEP;
      ST_GROW_EXT:  cmd_o = CMD_GROW_EXT;
      ST_GROW_CALC: cmd_o = CMD_GROW_CALC;
      ST_GROW_W1:   cmd_o = CMD_GROW_W1;
      ST_GROW_W2:   cmd_o = CMD_GROW_W2;
      ST_GROW_W3:   cmd_o = CMD_GROW_W3;
      ST_M_RD1:     cmd_o = CMD_M_RD1;
      ST_M_RD2:     cmd_o = CMD_M_RD2;
      ST_M_RD3:     cmd_o = CMD_M_RD3;
      ST_M_DEC:     cmd_o = CMD_M_DEC;
      ST_MP_W:      cmd_o = CMD_MP_W;
      ST_MP_R:      cmd_o = CMD_MP_R;
      ST_MP_W2:     cmd_o = CMD_MP_W2;
      ST_MQ_ADD:    cmd_o = CMD_MQ_ADD;
      ST_MN_W1:     cmd_o = CMD_MN_W1;
      ST_MN_W2:     cmd_o = CMD_MN_W2;
      ST_MB_ADD2:   cmd_o = CMD_MB_ADD2;
      ST_MB_W1:     cmd_o = CMD_MB_W1;
      ST_MB_R:      cmd_o = CMD_MB_R;
      ST_MB_W2:     cmd_o = CMD_MB_W2;
      ST_F_RD:      cmd_o = CMD_F_RD;
      ST_F_CHK:     cmd_o = CMD_F_CHK;
      ST_F_W1:      cmd_o = CMD_F_W1;
      ST_F_W2:      cmd_o = CMD_F_W2;
      ST_P_RD:      cmd_o = CMD_P_RD;
      ST_P_CHK:     cmd_o = CMD_P_CHK;
      ST_P_S1:      cmd_o = CMD_P_S1;
      ST_P_S2:      cmd_o = CMD_P_S2;
      ST_P_S3:      cmd_o = CMD_P_S3;
      ST_P_S4:      cmd_o = CMD_P_S4;
      ST_P_N1:      cmd_o = CMD_P_N1;
      ST_P_N2:      cmd_o = CMD_P_N2;
      ST_FAIL:      cmd_o = CMD_FAIL;
      ST_DONE:      cmd_o = CMD_PUBLISH;
      default:      cmd_o = CMD_NOP;
    endcase
  end

  // State registers; reset starts the init sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT0;
      mode_q  <= MODE_INIT;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule
